// ----- design/sjt_pkg.sv -----
`default_nettype none

package sjt_pkg;

   localparam int NUM_ENTRIES = 8;
   localparam logic [7:0] INVALID_ID = 8'hFF;

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int PEND_W = (NUM_ENTRIES < 8) ? NUM_ENTRIES : 8;
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_ACK    = 2'd1,
      OP_REJOIN = 2'd2,
      OP_PREP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_NOT_JOINED = 2'd0,
      ST_JOINING    = 2'd1,
      ST_JOINED     = 2'd2
   } join_type;

   // request token walking the row of cells
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [7:0]        sid;
      logic [7:0]        ivl;
      logic signed [7:0] ofs;
      logic              found;
      logic              free_found;
      logic [IDX_W-1:0]  free_idx;
      logic              ack;
      logic              inc;
      logic              dec;
      logic [7:0]        rsid;
      logic [7:0]        rivl;
      logic signed [7:0] rofs;
   } tok_type;

   // write of a new stream into a free slot, broadcast to all cells
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [7:0]        sid;
      logic [7:0]        ivl;
      logic signed [7:0] ofs;
   } fill_type;

endpackage

`default_nettype wire

// ----- design/sjt_cell.sv -----
`default_nettype none

module sjt_cell
   import sjt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_index,
   input  wire tok_type          tok_in,
   input  wire fill_type         fill,
   output tok_type               tok_out,
   output logic                  pending
);

   logic [7:0]        id_ff, id_in;
   logic [7:0]        ivl_ff, ivl_in;
   logic signed [7:0] ofs_ff, ofs_in;
   join_type          state_ff, state_in;
   logic              pend_ff, pend_in;
   tok_type           tok_ff, tok_in_next;

   always_comb begin
      id_in       = id_ff;
      ivl_in      = ivl_ff;
      ofs_in      = ofs_ff;
      state_in    = state_ff;
      pend_in     = pend_ff;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         case (tok_in.op)
            OP_ADD: begin
               if (!tok_in.found) begin
                  if (id_ff == tok_in.sid) begin
                     tok_in_next.found = 1'b1;
                     if (!(ivl_ff == tok_in.ivl && ofs_ff == tok_in.ofs)) begin
                        ivl_in   = tok_in.ivl;
                        ofs_in   = tok_in.ofs;
                        state_in = ST_JOINING;
                        pend_in  = 1'b1;
                     end
                  end else if (!tok_in.free_found && state_ff == ST_NOT_JOINED) begin
                     tok_in_next.free_found = 1'b1;
                     tok_in_next.free_idx   = cell_index;
                  end
               end
            end
            OP_ACK: begin
               if (!tok_in.found && id_ff == tok_in.sid) begin
                  tok_in_next.found = 1'b1;
                  pend_in = 1'b0;
                  if (ivl_ff != 8'd0) begin
                     tok_in_next.ack = 1'b1;
                     if (state_ff != ST_JOINED) begin
                        state_in = ST_JOINED;
                        tok_in_next.inc = 1'b1;
                     end
                  end else begin
                     // zero interval: leave the stream
                     if (state_ff != ST_NOT_JOINED) tok_in_next.dec = 1'b1;
                     state_in = ST_NOT_JOINED;
                  end
               end
            end
            OP_REJOIN: begin
               if (state_ff == ST_JOINED) begin
                  state_in = ST_JOINING;
                  pend_in  = 1'b1;
               end
            end
            OP_PREP: begin
               if (!tok_in.found && state_ff == ST_JOINING) begin
                  tok_in_next.found = 1'b1;
                  tok_in_next.rsid  = id_ff;
                  tok_in_next.rivl  = ivl_ff;
                  tok_in_next.rofs  = ofs_ff;
               end
            end
            default: ;
         endcase
      end else if (fill.en && fill.idx == cell_index) begin
         id_in    = fill.sid;
         ivl_in   = fill.ivl;
         ofs_in   = fill.ofs;
         state_in = ST_JOINING;
         pend_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff        <= INVALID_ID;
         ivl_ff       <= 8'd0;
         ofs_ff       <= 8'sd0;
         state_ff     <= ST_NOT_JOINED;
         pend_ff      <= 1'b0;
         tok_ff       <= '0;
      end else begin
         id_ff    <= id_in;
         ivl_ff   <= ivl_in;
         ofs_ff   <= ofs_in;
         state_ff <= state_in;
         pend_ff  <= pend_in;
         tok_ff   <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;
   assign pending = pend_ff;

endmodule

`default_nettype wire

// ----- design/sjt_ctrl.sv -----
`default_nettype none

module sjt_ctrl
   import sjt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [15:0]            csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_op,
   input  wire logic [7:0]             req_stream_id,
   input  wire logic [7:0]             req_interval,
   input  wire logic signed [7:0]      req_time_offset,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_ack_active,
   output logic                        rsp_req_valid,
   output logic [15:0]                 rsp_req_node_id,
   output logic [7:0]                  rsp_req_stream_id,
   output logic [7:0]                  rsp_req_interval,
   output logic signed [7:0]           rsp_req_offset,
   output logic [7:0]                  rsp_pending_bits,
   output logic [3:0]                  rsp_joined_total,
   output tok_type                     tok_head,
   input  wire tok_type                tok_tail,
   output fill_type                    fill,
   input  wire logic [NUM_ENTRIES-1:0] pend_vec
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } ctl_state_type;

   ctl_state_type     state_ff, state_in;
   logic [15:0]       node_id_ff, node_id_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   tok_type           hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ack_ff, ack_in;
   logic              rv_ff, rv_in;
   logic [15:0]       node_ff, node_in;
   logic [7:0]        rsid_ff, rsid_in;
   logic [7:0]        rivl_ff, rivl_in;
   logic signed [7:0] rofs_ff, rofs_in;
   logic [7:0]        pbits_ff, pbits_in;
   logic [3:0]        total_ff, total_in;
   logic              accept;
   logic              prep_hit;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign node_id_in = csr_wr_en ? csr_wr_data : node_id_ff;

   always_comb begin
      tok_head       = '0;
      tok_head.valid = accept;
      tok_head.op    = op_type'(req_op);
      tok_head.sid   = req_stream_id;
      tok_head.ivl   = req_interval;
      tok_head.ofs   = req_time_offset;
   end

   // place a new stream once the whole row has been searched
   always_comb begin
      fill.en  = (state_ff == S_SCAN) && tok_tail.valid && (tok_tail.op == OP_ADD) &&
                 !tok_tail.found && (tok_tail.ivl != 8'd0) && tok_tail.free_found;
      fill.idx = tok_tail.free_idx;
      fill.sid = tok_tail.sid;
      fill.ivl = tok_tail.ivl;
      fill.ofs = tok_tail.ofs;
   end

   assign prep_hit = (hold_ff.op == OP_PREP) && hold_ff.found;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ack_in       = ack_ff;
      rv_in        = rv_ff;
      node_in      = node_ff;
      rsid_in      = rsid_ff;
      rivl_in      = rivl_ff;
      rofs_in      = rofs_ff;
      pbits_in     = pbits_ff;
      total_in     = total_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (tok_tail.valid) begin
               hold_in = tok_tail;
               if (tok_tail.inc && count_ff != COUNT_MAX)
                  count_in = count_ff + 1'b1;
               else if (tok_tail.dec && count_ff != '0)
                  count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               ack_in   = (hold_ff.op == OP_ACK) && hold_ff.ack;
               rv_in    = prep_hit;
               node_in  = prep_hit ? node_id_ff : 16'd0;
               rsid_in  = prep_hit ? hold_ff.rsid : 8'd0;
               rivl_in  = prep_hit ? hold_ff.rivl : 8'd0;
               rofs_in  = prep_hit ? hold_ff.rofs : 8'sd0;
               pbits_in = 8'(pend_vec[PEND_W-1:0]);
               total_in = count_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         node_id_ff   <= 16'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_id_ff   <= node_id_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      ack_ff   <= ack_in;
      rv_ff    <= rv_in;
      node_ff  <= node_in;
      rsid_ff  <= rsid_in;
      rivl_ff  <= rivl_in;
      rofs_ff  <= rofs_in;
      pbits_ff <= pbits_in;
      total_ff <= total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ack_active    = ack_ff;
   assign rsp_req_valid     = rv_ff;
   assign rsp_req_node_id   = node_ff;
   assign rsp_req_stream_id = rsid_ff;
   assign rsp_req_interval  = rivl_ff;
   assign rsp_req_offset    = rofs_ff;
   assign rsp_pending_bits  = pbits_ff;
   assign rsp_joined_total  = total_ff;

endmodule

`default_nettype wire

// ----- design/stream_join_table.sv -----
// An accepted request travels as a token through the row of entry cells, one cell per cycle;
// a new stream is placed in a free slot in the cycle the token leaves the row. A new request
// is stalled until the previous one has left the scan and its result has been registered.
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) empties every entry at once, clears the pending mask,
// the joined count and the node id; the block takes requests in the next cycle.
`default_nettype none

module stream_join_table
   import sjt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [15:0]       csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_op,
   input  wire logic [7:0]        req_stream_id,
   input  wire logic [7:0]        req_interval,
   input  wire logic signed [7:0] req_time_offset,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_ack_active,
   output logic                   rsp_req_valid,
   output logic [15:0]            rsp_req_node_id,
   output logic [7:0]             rsp_req_stream_id,
   output logic [7:0]             rsp_req_interval,
   output logic signed [7:0]      rsp_req_offset,
   output logic [7:0]             rsp_pending_bits,
   output logic [3:0]             rsp_joined_total
);

   tok_type                chain [NUM_ENTRIES:0];
   fill_type               fill;
   logic [NUM_ENTRIES-1:0] pend_vec;

   sjt_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_stream_id     (req_stream_id),
      .req_interval      (req_interval),
      .req_time_offset   (req_time_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ack_active    (rsp_ack_active),
      .rsp_req_valid     (rsp_req_valid),
      .rsp_req_node_id   (rsp_req_node_id),
      .rsp_req_stream_id (rsp_req_stream_id),
      .rsp_req_interval  (rsp_req_interval),
      .rsp_req_offset    (rsp_req_offset),
      .rsp_pending_bits  (rsp_pending_bits),
      .rsp_joined_total  (rsp_joined_total),
      .tok_head          (chain[0]),
      .tok_tail          (chain[NUM_ENTRIES]),
      .fill              (fill),
      .pend_vec          (pend_vec)
   );

   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      sjt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .tok_in     (chain[i]),
         .fill       (fill),
         .tok_out    (chain[i+1]),
         .pending    (pend_vec[i])
      );
   end

endmodule

`default_nettype wire

// ----- design/sjt_checker.sv -----
`default_nettype none

module sjt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              csr_wr_en,
   input wire logic [15:0]       csr_wr_data,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic [1:0]        req_op,
   input wire logic [7:0]        req_stream_id,
   input wire logic [7:0]        req_interval,
   input wire logic signed [7:0] req_time_offset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_ack_active,
   input wire logic              rsp_req_valid,
   input wire logic [15:0]       rsp_req_node_id,
   input wire logic [7:0]        rsp_req_stream_id,
   input wire logic [7:0]        rsp_req_interval,
   input wire logic signed [7:0] rsp_req_offset,
   input wire logic [7:0]        rsp_pending_bits,
   input wire logic [3:0]        rsp_joined_total
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pending_bits) &&
      $stable(rsp_joined_total) && $stable(rsp_req_stream_id) && $stable(rsp_ack_active))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_ack_active && rsp_req_valid))
      else $error("acknowledge and prepare results both set");

   a_empty_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_req_valid |-> rsp_req_node_id == 16'd0 &&
      rsp_req_stream_id == 8'd0 && rsp_req_interval == 8'd0 && rsp_req_offset == 8'sd0)
      else $error("request fields set without a joining stream");

   // a request accepted while the previous one is in flight breaks the single-token scan
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken during a scan");

endmodule

bind stream_join_table sjt_checker u_sjt_checker (.*);

`default_nettype wire
